[hw/rtl/ofi_pkg.sv]
// ----------------------------------------------------------------------------
// Oblique forest inference package
// Shared codes, defaults and record layouts for the forest engine.
// ----------------------------------------------------------------------------
package ofi_pkg;

  // Transaction kinds carried on in_tuser.
  localparam logic [1:0] KIND_NODE    = 2'd0;
  localparam logic [1:0] KIND_LEAF    = 2'd1;
  localparam logic [1:0] KIND_FEATURE = 2'd2;
  localparam logic [1:0] KIND_PREDICT = 2'd3;

  // Default sizes of the forest.
  localparam int DEF_TREES      = 16;
  localparam int DEF_TREE_DEPTH = 5;
  localparam int DEF_FEATURES   = 16;

  // Fixed field widths.
  localparam int FIDX_W = 4;
  localparam int W_W    = 16;
  localparam int THR_W  = 48;
  localparam int CNT_W  = 20;
  localparam int FV_W   = 32;
  localparam int PROB_W = 16;
  localparam int TC_W   = 5;

  localparam logic [TC_W-1:0] TREE_COUNT_RST = 5'd16;

  // Probability of one half in Q0.16.
  localparam logic [PROB_W-1:0] PROB_HALF = 16'h8000;

  // Stored internal node.
  typedef struct packed {
    logic             failed;
    logic [THR_W-1:0] thr;
    logic [W_W-1:0]   wb;
    logic [W_W-1:0]   wa;
    logic [FIDX_W-1:0] fb;
    logic [FIDX_W-1:0] fa;
  } node_rec_t;

  // Stored leaf counts.
  typedef struct packed {
    logic [CNT_W-1:0] neg;
    logic [CNT_W-1:0] pos;
  } leaf_rec_t;

endpackage

[hw/rtl/oblique_forest_inference.sv]
// ----------------------------------------------------------------------------
// Oblique forest inference
// Loads an oblique-split forest and one sample, then predicts on request.
// ----------------------------------------------------------------------------
// After reset the block sweeps its node and leaf memories and takes no
// transaction until that is done. A predict walks the trees one node test at a
// time through a single shared 32x16 multiplier: each level reads the node,
// fetches both features, multiplies twice and compares; each tree then reads
// its leaf, divides for the leaf value and accumulates it. A final 16-step
// division and a hand-off state finish the average. The result is held on
// out_tdata until taken.
// ----------------------------------------------------------------------------
module oblique_forest_inference
  import ofi_pkg::*;
#(
  parameter int TREES      = DEF_TREES,
  parameter int TREE_DEPTH = DEF_TREE_DEPTH,
  parameter int FEATURES   = DEF_FEATURES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [3:0] tree_index, [8:4] node_index, [12:9] feature_first,
  // [16:13] feature_second, [32:17] weight_first, [48:33] weight_second,
  // [96:49] threshold, [97] node_failed, [117:98] positive_count,
  // [137:118] negative_count, [169:138] feature_value, [175:170] zero
  input  logic [175:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] probability, [16] label, [23:17] zero
  output logic [23:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [4:0]   cfg_wr_data
);

  localparam int NODES   = (1 << TREE_DEPTH) - 1;
  localparam int LEAVES  = 1 << TREE_DEPTH;
  localparam int NDEPTH  = TREES * NODES;
  localparam int LDEPTH  = TREES * LEAVES;
  localparam int NA_W    = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
  localparam int LA_W    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int FA_W    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int N_W     = TREE_DEPTH + 1;
  localparam int LV_W    = $clog2(TREE_DEPTH + 1);
  localparam int T_W     = $clog2(TREES + 1);
  localparam int SUM_W   = PROB_W + T_W;
  localparam int DEN_W   = CNT_W + 2;
  localparam int REM_W   = DEN_W + 1;
  localparam int PROD_W  = FV_W + W_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int STEP_W  = $clog2(PROB_W);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_NRD   = 4'd2;
  localparam logic [3:0] S_FA    = 4'd3;
  localparam logic [3:0] S_FB    = 4'd4;
  localparam logic [3:0] S_MB    = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_LRD   = 4'd7;
  localparam logic [3:0] S_LINIT = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // Input field views.
  logic [3:0]        f_tree;
  logic [4:0]        f_node;
  logic [FIDX_W-1:0] f_fa, f_fb;
  logic [W_W-1:0]    f_wa, f_wb;
  logic [THR_W-1:0]  f_thr;
  logic              f_failed;
  logic [CNT_W-1:0]  f_pos, f_neg;
  logic [FV_W-1:0]   f_fval;

  assign f_tree   = in_tdata[3:0];
  assign f_node   = in_tdata[8:4];
  assign f_fa     = in_tdata[12:9];
  assign f_fb     = in_tdata[16:13];
  assign f_wa     = in_tdata[32:17];
  assign f_wb     = in_tdata[48:33];
  assign f_thr    = in_tdata[96:49];
  assign f_failed = in_tdata[97];
  assign f_pos    = in_tdata[117:98];
  assign f_neg    = in_tdata[137:118];
  assign f_fval   = in_tdata[169:138];

  logic [3:0]        state_r, state_nxt;
  logic [LA_W-1:0]   clr_r, clr_nxt;
  logic [TC_W-1:0]   tree_count_r;
  logic [T_W-1:0]    cnt_r, cnt_nxt;
  logic [T_W-1:0]    t_r, t_nxt;
  logic [NA_W-1:0]   nbase_r, nbase_nxt;
  logic [LA_W-1:0]   lbase_r, lbase_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic [LV_W-1:0]   lvl_r, lvl_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [PROB_W-1:0] low_r, low_nxt;
  logic [PROB_W-1:0] q_r, q_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              avg_r, avg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PROB_W-1:0] out_prob_r;
  logic              out_label_r;

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_count_r <= TREE_COUNT_RST;
    end else if (cfg_wr_en) begin
      tree_count_r <= cfg_wr_data;
    end
  end

  // Node memory: one write port shared by the sweep and node writes.
  node_rec_t         node_mem [NDEPTH];
  node_rec_t         node_rd_r;
  node_rec_t         node_wd;
  logic              node_we;
  logic [NA_W-1:0]   node_wa;
  logic [NA_W-1:0]   node_ra;
  logic [31:0]       node_wa_full;

  assign node_wa_full = 32'(f_tree) * NODES + 32'(f_node);

  always_comb begin
    node_wd  = '{failed: f_failed, thr: f_thr, wb: f_wb, wa: f_wa, fb: f_fb, fa: f_fa};
    node_wa  = NA_W'(node_wa_full);
    node_we  = in_acc && (in_tuser == KIND_NODE) && (32'(f_tree) < TREES) &&
               (32'(f_node) < NODES);
    if (state_r == S_CLEAR) begin
      node_wd        = '0;
      node_wd.failed = 1'b1;
      node_wa        = NA_W'(clr_r);
      node_we        = (32'(clr_r) < NDEPTH);
    end
  end

  assign node_ra = NA_W'(32'(nbase_r) + 32'(n_r));

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (state_r == S_NRD) begin
      node_rd_r <= node_mem[node_ra];
    end
  end

  // Leaf memory.
  leaf_rec_t         leaf_mem [LDEPTH];
  leaf_rec_t         leaf_rd_r;
  leaf_rec_t         leaf_wd;
  logic              leaf_we;
  logic [LA_W-1:0]   leaf_wa;
  logic [LA_W-1:0]   leaf_ra;
  logic [31:0]       leaf_wa_full;

  assign leaf_wa_full = 32'(f_tree) * LEAVES + 32'(f_node);

  always_comb begin
    leaf_wd = '{neg: f_neg, pos: f_pos};
    leaf_wa = LA_W'(leaf_wa_full);
    leaf_we = in_acc && (in_tuser == KIND_LEAF) && (32'(f_tree) < TREES) &&
              (32'(f_node) < LEAVES);
    if (state_r == S_CLEAR) begin
      leaf_wd = '0;
      leaf_wa = clr_r;
      leaf_we = 1'b1;
    end
  end

  assign leaf_ra = LA_W'(32'(lbase_r) + 32'(n_r) - NODES);

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= leaf_wd;
    end
    if (state_r == S_LRD) begin
      leaf_rd_r <= leaf_mem[leaf_ra];
    end
  end

  // Feature memory; an index beyond the store reads as zero.
  logic [FV_W-1:0]   feat_mem [FEATURES];
  logic [FV_W-1:0]   feat_rd_r;
  logic              feat_ok_r;
  logic [FIDX_W-1:0] feat_ridx;
  logic              feat_we;

  assign feat_ridx = (state_r == S_FA) ? node_rd_r.fa : node_rd_r.fb;
  assign feat_we   = in_acc && (in_tuser == KIND_FEATURE) && (32'(f_fa) < FEATURES);

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[FA_W'(f_fa)] <= f_fval;
    end
    if ((state_r == S_FA) || (state_r == S_FB)) begin
      feat_rd_r <= feat_mem[FA_W'(feat_ridx)];
      feat_ok_r <= (32'(feat_ridx) < FEATURES);
    end
  end

  // Shared multiplier: first weight in S_FB, second weight in S_MB.
  logic signed [FV_W-1:0]   mul_x;
  logic signed [W_W-1:0]    mul_w;
  logic signed [PROD_W-1:0] prod_r, acc_r;
  logic signed [DOT_W-1:0]  dot;
  logic                     go_left;

  assign mul_x = feat_ok_r ? signed'(feat_rd_r) : '0;
  assign mul_w = (state_r == S_FB) ? signed'(node_rd_r.wa) : signed'(node_rd_r.wb);

  always_ff @(posedge clk) begin
    if ((state_r == S_FB) || (state_r == S_MB)) begin
      prod_r <= mul_x * mul_w;
    end
    if (state_r == S_MB) begin
      acc_r <= prod_r;
    end
  end

  assign dot     = DOT_W'(acc_r) + DOT_W'(prod_r);
  assign go_left = !node_rd_r.failed && (dot < DOT_W'(signed'(node_rd_r.thr)));

  // Shared restoring divider step.
  logic [REM_W-1:0] rem_sh;
  logic             rem_ge;
  assign rem_sh = {rem_r[REM_W-2:0], low_r[PROB_W-1]};
  assign rem_ge = (rem_sh >= REM_W'(den_r));

  // Effective tree count.
  logic [T_W-1:0] cnt_eff;
  always_comb begin
    if (tree_count_r == '0) begin
      cnt_eff = T_W'(1);
    end else if (32'(tree_count_r) > TREES) begin
      cnt_eff = T_W'(TREES);
    end else begin
      cnt_eff = T_W'(tree_count_r);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    nbase_nxt     = nbase_r;
    lbase_nxt     = lbase_r;
    n_nxt         = n_r;
    lvl_nxt       = lvl_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    low_nxt       = low_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == LDEPTH - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && (in_tuser == KIND_PREDICT)) begin
          cnt_nxt   = cnt_eff;
          t_nxt     = '0;
          nbase_nxt = '0;
          lbase_nxt = '0;
          n_nxt     = '0;
          lvl_nxt   = '0;
          sum_nxt   = '0;
          avg_nxt   = 1'b0;
          state_nxt = S_NRD;
        end
      end
      S_NRD: state_nxt = S_FA;
      S_FA:  state_nxt = S_FB;
      S_FB:  state_nxt = S_MB;
      S_MB:  state_nxt = S_CMP;
      S_CMP: begin
        n_nxt   = go_left ? N_W'({n_r, 1'b1}) : N_W'({n_r, 1'b0} + 2'd2);
        lvl_nxt = lvl_r + 1'b1;
        state_nxt = (32'(lvl_r) == TREE_DEPTH - 1) ? S_LRD : S_NRD;
      end
      S_LRD: state_nxt = S_LINIT;
      S_LINIT: begin
        // Leaf value: (2p+1)*65536 / (2p+2n+2), with 2p+1 below the divisor.
        rem_nxt   = REM_W'({leaf_rd_r.pos, 1'b1});
        den_nxt   = DEN_W'({leaf_rd_r.pos, 1'b0}) + DEN_W'({leaf_rd_r.neg, 1'b0}) +
                    DEN_W'(2);
        low_nxt   = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = rem_ge ? (rem_sh - REM_W'(den_r)) : rem_sh;
        q_nxt    = {q_r[PROB_W-2:0], rem_ge};
        low_nxt  = {low_r[PROB_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(PROB_W - 1)) begin
          state_nxt = avg_r ? S_DONE : S_ACC;
        end
      end
      S_ACC: begin
        sum_nxt   = sum_r + SUM_W'(q_r);
        t_nxt     = t_r + 1'b1;
        nbase_nxt = NA_W'(32'(nbase_r) + NODES);
        lbase_nxt = LA_W'(32'(lbase_r) + LEAVES);
        n_nxt     = '0;
        lvl_nxt   = '0;
        if (t_r == cnt_r - 1'b1) begin
          // Average: the high part of the sum is below the tree count.
          rem_nxt   = REM_W'(sum_nxt >> PROB_W);
          den_nxt   = DEN_W'(cnt_r);
          low_nxt   = sum_nxt[PROB_W-1:0];
          step_nxt  = '0;
          avg_nxt   = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_NRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    t_r     <= t_nxt;
    nbase_r <= nbase_nxt;
    lbase_r <= lbase_nxt;
    n_r     <= n_nxt;
    lvl_r   <= lvl_nxt;
    sum_r   <= sum_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    low_r   <= low_nxt;
    q_r     <= q_nxt;
    step_r  <= step_nxt;
    avg_r   <= avg_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && !out_valid_r) begin
      out_prob_r  <= q_r;
      out_label_r <= (q_r > PROB_HALF);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_label_r, out_prob_r};

endmodule

[hw/rtl/ofi_checker.sv]
// ----------------------------------------------------------------------------
// Oblique forest inference checker
// Port-level checks on the forest engine, bound to the top level.
// ----------------------------------------------------------------------------
module ofi_checker
  import ofi_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [23:0]  out_tdata
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  // A stalled result keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // The label agrees with the probability.
  a_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16] == (out_tdata[15:0] > PROB_HALF)))
    else $error("label disagrees with probability");

  // A predict keeps the input side busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_PREDICT) |=> !in_tready)
    else $error("input ready right after a predict");

endmodule

bind oblique_forest_inference ofi_checker u_ofi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oblique forest inference testbench
// Loads features, nodes and leaves through the input stream and requests
// predictions. A local copy of the forest predicts every probability and
// label, and the monitor compares each output transaction with the oldest
// prediction. The tree count is changed between phases while the block idles.
// ----------------------------------------------------------------------------
module testbench;
  import ofi_pkg::*;

  localparam int TREES       = DEF_TREES;
  localparam int TREE_DEPTH  = DEF_TREE_DEPTH;
  localparam int FEATURES    = DEF_FEATURES;
  localparam int NODES       = (1 << TREE_DEPTH) - 1;
  localparam int LEAVES      = 1 << TREE_DEPTH;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]        kind;
    logic [3:0]        tree;
    logic [4:0]        node;
    logic [FIDX_W-1:0] fa;
    logic [FIDX_W-1:0] fb;
    logic [W_W-1:0]    wa;
    logic [W_W-1:0]    wb;
    logic [THR_W-1:0]  thr;
    logic              failed;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  neg;
    logic [FV_W-1:0]   fval;
  } forest_item_t;

  typedef struct {
    logic [PROB_W-1:0] prob;
    logic              label;
  } prediction_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [4:0]   cfg_wr_data = '0;

  // Local copy of the forest, the sample and the tree count.
  node_rec_t      node_copy [TREES*NODES];
  leaf_rec_t      leaf_copy [TREES*LEAVES];
  logic [FV_W-1:0] sample_copy [FEATURES];
  logic [TC_W-1:0] trees_used;

  forest_item_t pending_items[$];
  prediction_t  awaited_predictions[$];
  forest_item_t current_item;
  bit           sending = 0;
  bit           calm = 0;
  int           send_gap = 0;
  int           sink_stall = 0;
  int           error_count = 0;
  int           cycle_count = 0;

  oblique_forest_inference dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] %s mismatch: got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Walks every averaged tree and averages the leaf probabilities.
  function automatic prediction_t predict_forest();
    prediction_t res;
    longint unsigned sum;
    longint unsigned p;
    longint unsigned n;
    longint dot;
    longint xa;
    longint xb;
    int count;
    int idx;
    node_rec_t nd;
    sum = 0;
    count = trees_used;
    if (count == 0) count = 1;
    if (count > TREES) count = TREES;
    for (int t = 0; t < count; t++) begin
      idx = 0;
      for (int lvl = 0; lvl < TREE_DEPTH; lvl++) begin
        nd = node_copy[t*NODES + idx];
        xa = (nd.fa < FEATURES) ? longint'($signed(sample_copy[nd.fa])) : 0;
        xb = (nd.fb < FEATURES) ? longint'($signed(sample_copy[nd.fb])) : 0;
        dot = xa * longint'($signed(nd.wa)) + xb * longint'($signed(nd.wb));
        if (!nd.failed && dot < longint'($signed(nd.thr))) idx = 2*idx + 1;
        else idx = 2*idx + 2;
      end
      p = leaf_copy[t*LEAVES + idx - NODES].pos;
      n = leaf_copy[t*LEAVES + idx - NODES].neg;
      sum += ((2*p + 1) << 16) / (2*p + 2*n + 2);
    end
    res.prob = PROB_W'(sum / count);
    res.label = res.prob > PROB_HALF;
    return res;
  endfunction

  // Updates the local copy for one accepted transaction.
  task automatic absorb_item(forest_item_t it);
    case (it.kind)
      KIND_NODE: begin
        if (it.node < NODES)
          node_copy[it.tree*NODES + it.node] =
            '{failed: it.failed, thr: it.thr, wb: it.wb, wa: it.wa, fb: it.fb, fa: it.fa};
      end
      KIND_LEAF: begin
        leaf_copy[it.tree*LEAVES + it.node] = '{neg: it.neg, pos: it.pos};
      end
      KIND_FEATURE: begin
        sample_copy[it.fa] = it.fval;
      end
      default: begin
        awaited_predictions.push_back(predict_forest());
      end
    endcase
  endtask

  // Builds a random item; thresholds and features mostly stay near dot scale.
  function automatic forest_item_t random_item(logic [1:0] kind);
    forest_item_t it;
    it.kind   = kind;
    it.tree   = 4'($urandom);
    it.node   = 5'($urandom);
    it.fa     = 4'($urandom);
    it.fb     = 4'($urandom);
    it.wa     = W_W'($urandom_range(0, 32768) - 16384);
    it.wb     = W_W'($urandom_range(0, 32768) - 16384);
    if ($urandom_range(0, 3) == 0) it.thr = {16'($urandom), 32'($urandom)};
    else it.thr = THR_W'(longint'($signed(32'($urandom))) * ($urandom_range(0, 20000) - 10000));
    it.failed = ($urandom_range(0, 7) == 0);
    it.pos    = ($urandom_range(0, 1) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 50));
    it.neg    = ($urandom_range(0, 1) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 50));
    it.fval   = ($urandom_range(0, 2) == 0) ? FV_W'($urandom)
                : FV_W'($urandom_range(0, 1 << 20) - (1 << 19));
    return it;
  endfunction

  function automatic logic [1:0] random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return KIND_NODE;
    if (r < 65) return KIND_LEAF;
    if (r < 82) return KIND_FEATURE;
    return KIND_PREDICT;
  endfunction

  // Input driver: one transaction held until accepted, random gaps between.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) trees_used = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        absorb_item(current_item);
        sending = 0;
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          current_item = pending_items.pop_front();
          sending = 1;
          if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 11);
        end
      end
      in_tvalid <= sending;
      in_tuser  <= current_item.kind;
      in_tdata  <= {6'd0, current_item.fval, current_item.neg, current_item.pos,
                    current_item.failed, current_item.thr, current_item.wb,
                    current_item.wa, current_item.fb, current_item.fa,
                    current_item.node, current_item.tree};
    end
  end

  // Output monitor with random back-pressure.
  always @(posedge clk) begin
    prediction_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_predictions.size() == 0) begin
          report_mismatch("unexpected transaction", out_tdata[15:0], -1);
        end else begin
          want = awaited_predictions.pop_front();
          if (out_tdata[15:0] !== want.prob)
            report_mismatch("probability", out_tdata[15:0], want.prob);
          if (out_tdata[16] !== want.label)
            report_mismatch("label", out_tdata[16], want.label);
        end
      end
      if (sink_stall > 0) sink_stall--;
      else if (!calm && $urandom_range(0, 11) == 0) sink_stall = $urandom_range(1, 11);
      out_tready <= (sink_stall == 0);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d predictions outstanding",
               awaited_predictions.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    wait (pending_items.size() == 0 && !sending && awaited_predictions.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_tree_count(logic [4:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Stimulus sequence.
  initial begin
    forest_item_t it;
    logic [4:0] settings [6];
    settings = '{5'd0, 5'd31, 5'd1, 5'd7, 5'd16, 5'd12};
    foreach (node_copy[i]) node_copy[i] = '{failed: 1'b1, default: '0};
    foreach (leaf_copy[i]) leaf_copy[i] = '0;
    foreach (sample_copy[i]) sample_copy[i] = '0;
    trees_used = TREE_COUNT_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the whole sample first, including both extremes.
    for (int f = 0; f < FEATURES; f++) begin
      it = random_item(KIND_FEATURE);
      it.fa = FIDX_W'(f);
      if (f == 0) it.fval = 32'h8000_0000;
      if (f == 1) it.fval = 32'h7FFF_FFFF;
      if (f == 2) it.fval = '0;
      pending_items.push_back(it);
    end
    // Prediction on an unwritten forest: all nodes failed, all leaves empty.
    pending_items.push_back(random_item(KIND_PREDICT));
    // Root of tree 0 with extreme weights and extreme threshold.
    it = random_item(KIND_NODE);
    it.tree = 4'd0; it.node = 5'd0; it.fa = 4'd0; it.fb = 4'd1; it.failed = 1'b0;
    it.wa = 16'hC000; it.wb = 16'h4000; it.thr = 48'h7FFF_FFFF_FFFF;
    pending_items.push_back(it);
    // Write beyond the last internal node is ignored.
    it.node = 5'd31; it.thr = 48'h8000_0000_0000;
    pending_items.push_back(it);
    // Failed root in the last tree.
    it = random_item(KIND_NODE);
    it.tree = 4'd15; it.node = 5'd0; it.failed = 1'b1;
    pending_items.push_back(it);
    // Leaf counts at both extremes.
    it = random_item(KIND_LEAF);
    it.tree = 4'd0; it.node = 5'd31; it.pos = '1; it.neg = '0;
    pending_items.push_back(it);
    it.tree = 4'd15; it.node = 5'd0; it.pos = '0; it.neg = '1;
    pending_items.push_back(it);
    pending_items.push_back(random_item(KIND_PREDICT));
    wait_idle();

    // Random phases, each under its own tree count; the last one runs calm.
    for (int ph = 0; ph < 6; ph++) begin
      set_tree_count(settings[ph]);
      if (ph == 5) calm = 1;
      for (int k = 0; k < 195; k++) pending_items.push_back(random_item(random_kind()));
      pending_items.push_back(random_item(KIND_PREDICT));
      wait_idle();
    end

    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
